// ----- hdl/lpip_pkg.sv -----
// lpip_pkg: shared types, codes and constants for the length-prefixed
// instruction parser. No dependencies.
`default_nettype none
package lpip_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_FRAME_BYTES   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ELEMENT_BYTES = 1'd1;

   localparam logic [15:0] MAX_FRAME_BYTES_RESET   = 16'd6144;
   localparam logic [15:0] MAX_ELEMENT_BYTES_RESET = 16'd3450;

   // parser phases
   localparam logic [2:0] PH_FIRST_DIGIT = 3'd0;
   localparam logic [2:0] PH_DIGITS      = 3'd1;
   localparam logic [2:0] PH_CONTENT     = 3'd2;
   localparam logic [2:0] PH_SEPARATOR   = 3'd3;
   localparam logic [2:0] PH_DONE        = 3'd4;
   localparam logic [2:0] PH_ERROR       = 3'd5;

   // frame status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_SEMI    = 3'd1;
   localparam logic [2:0] ST_TOO_LONG   = 3'd2;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
   localparam logic [2:0] ST_NO_PERIOD  = 3'd4;
   localparam logic [2:0] ST_BAD_SEP    = 3'd5;
   localparam logic [2:0] ST_TRUNCATED  = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_CONTENT = 2'd0;
   localparam logic [1:0] KIND_CLOSE   = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   // framing characters
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // saturation limits
   localparam logic [16:0] ACCUM_SAT = 17'd65536;
   localparam logic [16:0] COUNT_SAT = 17'd131071;
   localparam logic [15:0] INDEX_SAT = 16'd65535;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // what one input byte produced: an optional element result and an
   // optional frame status result
   typedef struct packed {
      logic        has_elem;
      logic [1:0]  elem_kind;
      logic [7:0]  content_val;
      logic [15:0] elem_num;
      logic        has_status;
      logic [2:0]  status;
      logic [15:0] status_num;
   } rec_type;

endpackage
`default_nettype wire

// ----- hdl/lpip_front.sv -----
// lpip_front: per-byte frame parser; classifies each byte and builds a
// result record. Depends on lpip_pkg.
`default_nettype none
module lpip_front import lpip_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        take,
   input  wire logic [7:0]  data_byte,
   input  wire logic        frame_end,
   input  wire logic [15:0] max_frame_bytes,
   input  wire logic [15:0] max_element_bytes,
   output rec_type          rec,
   output logic             rec_any
);

   logic [2:0]  phase_ff, phase_in;
   logic [16:0] accum_ff, accum_in;
   logic [15:0] left_ff, left_in;
   logic [16:0] count_ff, count_in;
   logic [15:0] index_ff, index_in;
   logic [2:0]  err_ff, err_in;

   logic        is_digit;
   logic [20:0] accum_x10;
   logic [15:0] left_dec;

   assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign accum_x10 = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1)
                    + {17'd0, data_byte[3:0]};
   assign left_dec  = left_ff - 16'd1;

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      left_in  = left_ff;
      index_in = index_ff;
      err_in   = err_ff;
      count_in = (count_ff < COUNT_SAT) ? count_ff + 17'd1 : count_ff;

      rec             = '0;
      rec.elem_kind   = KIND_CONTENT;
      rec.elem_num    = index_ff;

      case (phase_ff)
         PH_FIRST_DIGIT, PH_DIGITS: begin
            if (is_digit) begin
               accum_in = (accum_x10 > {4'd0, ACCUM_SAT}) ? ACCUM_SAT : accum_x10[16:0];
               phase_in = PH_DIGITS;
            end else if (phase_ff == PH_FIRST_DIGIT
                         || accum_ff >= {1'b0, max_element_bytes}) begin
               err_in   = (err_ff == ST_OK) ? ST_BAD_LENGTH : err_ff;
               phase_in = PH_ERROR;
            end else if (data_byte != CHAR_PERIOD) begin
               err_in   = (err_ff == ST_OK) ? ST_NO_PERIOD : err_ff;
               phase_in = PH_ERROR;
            end else begin
               left_in  = accum_ff[15:0];
               accum_in = '0;
               phase_in = (accum_ff[15:0] == 16'd0) ? PH_SEPARATOR : PH_CONTENT;
            end
         end
         PH_CONTENT: begin
            rec.has_elem    = 1'b1;
            rec.content_val = data_byte;
            left_in         = left_dec;
            if (left_dec == 16'd0) begin
               phase_in = PH_SEPARATOR;
            end
         end
         PH_SEPARATOR: begin
            if (data_byte == CHAR_COMMA || data_byte == CHAR_SEMI) begin
               rec.has_elem  = 1'b1;
               rec.elem_kind = KIND_CLOSE;
               if (index_ff < INDEX_SAT) begin
                  index_in = index_ff + 16'd1;
               end
               phase_in = (data_byte == CHAR_COMMA) ? PH_FIRST_DIGIT : PH_DONE;
            end else begin
               err_in   = (err_ff == ST_OK) ? ST_BAD_SEP : err_ff;
               phase_in = PH_ERROR;
            end
         end
         default: begin
         end
      endcase

      if (frame_end) begin
         rec.has_status = 1'b1;
         rec.status_num = index_in;
         if (data_byte != CHAR_SEMI) begin
            rec.status = ST_NO_SEMI;
         end else if (count_in >= {1'b0, max_frame_bytes}) begin
            rec.status = ST_TOO_LONG;
         end else if (err_in != ST_OK) begin
            rec.status = err_in;
         end else if (phase_in != PH_DONE) begin
            rec.status = ST_TRUNCATED;
         end else begin
            rec.status = ST_OK;
         end
         // frame state clears for the next frame
         phase_in = PH_FIRST_DIGIT;
         accum_in = '0;
         left_in  = '0;
         count_in = '0;
         index_in = '0;
         err_in   = ST_OK;
      end
   end

   assign rec_any = rec.has_elem || rec.has_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST_DIGIT;
         accum_ff <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         index_ff <= '0;
         err_ff   <= ST_OK;
      end else if (take) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         index_ff <= index_in;
         err_ff   <= err_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/lpip_queue.sv -----
// lpip_queue: small register FIFO of result records between parser and
// output sequencer. Depends on lpip_pkg.
`default_nettype none
module lpip_queue import lpip_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rec_type push_rec,
   input  wire logic    pop,
   output rec_type      head_rec,
   output logic         empty,
   output logic         full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   rec_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == FULL_CNT);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_rec = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_rec;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/lpip_back.sv -----
// lpip_back: output sequencer; unpacks each record into one or two result
// transactions through an output register. Depends on lpip_pkg.
`default_nettype none
module lpip_back import lpip_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire rec_type head_rec,
   input  wire logic    head_valid,
   output logic         head_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [1:0]   rsp_kind,
   output logic [7:0]   rsp_content_byte,
   output logic [15:0]  rsp_element_number,
   output logic [2:0]   rsp_status,
   output logic         rsp_last
);

   logic        valid_ff;
   logic        second_ff, second_in;  // element part of head already sent
   logic        load, send_status;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  content_ff, content_in;
   logic [15:0] num_ff, num_in;
   logic [2:0]  status_ff, status_in;
   logic        last_ff, last_in;

   assign load        = head_valid && (!valid_ff || !rsp_stall);
   assign send_status = second_ff || !head_rec.has_elem;

   always_comb begin
      second_in = second_ff;
      head_pop  = 1'b0;
      if (send_status) begin
         kind_in    = KIND_STATUS;
         content_in = '0;
         num_in     = head_rec.status_num;
         status_in  = head_rec.status;
         last_in    = 1'b1;
      end else begin
         kind_in    = head_rec.elem_kind;
         content_in = head_rec.content_val;
         num_in     = head_rec.elem_num;
         status_in  = ST_OK;
         last_in    = 1'b0;
      end
      if (load) begin
         if (!send_status && head_rec.has_status) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            head_pop  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         content_ff <= content_in;
         num_ff     <= num_in;
         status_ff  <= status_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_content_byte   = content_ff;
   assign rsp_element_number = num_ff;
   assign rsp_status         = status_ff;
   assign rsp_last           = last_ff;

endmodule
`default_nettype wire

// ----- hdl/length_prefixed_instruction_parser.sv -----
// length_prefixed_instruction_parser: top level; csr registers, parser front,
// record queue and output sequencer. Depends on lpip_pkg and lpip_* modules.
//
// Usage:
//  - req channel: one frame byte per transaction (req_data_byte), with
//    req_frame_end high on the last byte of the frame. Frames are
//    "<len>.<content>," ... "<len>.<content>;".
//  - rsp channel: content bytes (kind 0) tagged with element number, an
//    element-closed result (kind 1) per separator, and on frame end a status
//    result (kind 2, rsp_last high). Non-zero status means discard the frame.
//  - csr port: index 0 max_frame_bytes, index 1 max_element_bytes; write
//    only while idle.
//  - Throughput: one byte per cycle while req_stall is low. Results leave at
//    one per cycle while rsp_stall is low, so a frame-end byte that also closes
//    an element produces two output results.
//  - Path: a result passes through the queue and then the output register
//    before it is valid on rsp.
//  - Reset: parser returns to expecting a length, csrs take their defaults,
//    queue and output empty.
//  - rsp_stall holds the output register; the queue keeps filling, and
//    req_stall rises only when the queue is full.
`default_nettype none
module length_prefixed_instruction_parser import lpip_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // byte input
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_frame_end,
   // results
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_content_byte,
   output logic [15:0]                     rsp_element_number,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_last,
   // configuration writes
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [15:0] max_frame_ff;
   logic [15:0] max_elem_ff;

   rec_type     front_rec;
   rec_type     head_rec;
   logic        front_any;
   logic        take;
   logic        q_empty, q_full, q_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= MAX_FRAME_BYTES_RESET;
         max_elem_ff  <= MAX_ELEMENT_BYTES_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_FRAME_BYTES:   max_frame_ff <= csr_write_data;
            CSR_MAX_ELEMENT_BYTES: max_elem_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // byte accepted whenever the queue has room
   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   lpip_front u_front (
      .clock             (clock),
      .reset             (reset),
      .take              (take),
      .data_byte         (req_data_byte),
      .frame_end         (req_frame_end),
      .max_frame_bytes   (max_frame_ff),
      .max_element_bytes (max_elem_ff),
      .rec               (front_rec),
      .rec_any           (front_any)
   );

   // bytes that produce nothing never enter the queue
   lpip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take && front_any),
      .push_rec (front_rec),
      .pop      (q_pop),
      .head_rec (head_rec),
      .empty    (q_empty),
      .full     (q_full)
   );

   lpip_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_rec           (head_rec),
      .head_valid         (!q_empty),
      .head_pop           (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_content_byte   (rsp_content_byte),
      .rsp_element_number (rsp_element_number),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for length_prefixed_instruction_parser.
// Holds its own frame parser prediction, stimulus and result checking.
// Depends on lpip_pkg and the parser RTL.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lpip_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1400;
   localparam int LONG_HOLD    = 120;  // receiver hold-off for the pressure test
   localparam int DRAIN_CYCLES = 6;    // queue and output register path plus margin for silent bytes

   // one result transaction as seen on the rsp channel
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  content;
      logic [15:0] elem;
      logic [2:0]  status;
      logic        last;
   } parse_result_type;

   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_data_byte  = 8'h00;
   logic                       req_frame_end  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic [1:0]                 rsp_kind;
   logic [7:0]                 rsp_content_byte;
   logic [15:0]                rsp_element_number;
   logic [2:0]                 rsp_status;
   logic                       rsp_last;
   logic                       csr_write_en   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index      = CSR_MAX_FRAME_BYTES;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   length_prefixed_instruction_parser u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_frame_end      (req_frame_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_content_byte   (rsp_content_byte),
      .rsp_element_number (rsp_element_number),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   parse_result_type pending_results[$];  // results the parser still owes us
   logic [7:0]    frame_buf[$];        // frame under construction
   int            fail_count   = 0;
   int            items_sent   = 0;
   int            cycle_count  = 0;
   bit            tx_idling    = 1'b1; // sender inserts random gaps
   bit            rx_idling    = 1'b1; // receiver stalls at random
   bit            hold_pending = 1'b0; // request one long receiver hold-off

   // ------------------------------------------------------------------
   // Parser prediction: our own copy of the frame state and the limits
   // ------------------------------------------------------------------
   logic [2:0]  prs_phase;
   logic [16:0] len_acc;      // decimal length being accumulated, saturating
   logic [15:0] bytes_left;   // content bytes still owed by this element
   logic [16:0] frame_len;    // bytes seen in this frame, saturating
   logic [15:0] elem_idx;     // elements closed so far, saturating
   logic [2:0]  first_err;
   logic [15:0] lim_frame = MAX_FRAME_BYTES_RESET;
   logic [15:0] lim_elem  = MAX_ELEMENT_BYTES_RESET;

   function automatic void clear_frame_state();
      prs_phase  = PH_FIRST_DIGIT;
      len_acc    = '0;
      bytes_left = '0;
      frame_len  = '0;
      elem_idx   = '0;
      first_err  = ST_OK;
   endfunction

   // only the first error of a frame is kept; the rest of the frame is dead
   function automatic void note_error(input logic [2:0] code);
      if (first_err == ST_OK)
         first_err = code;
      prs_phase = PH_ERROR;
   endfunction

   function automatic void parse_frame_byte(input logic [7:0] b, input logic fe);
      logic        is_digit;
      int unsigned acc;
      logic [2:0]  st;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      if (frame_len < COUNT_SAT)
         frame_len = frame_len + 17'd1;

      case (prs_phase)
         PH_FIRST_DIGIT, PH_DIGITS: begin
            if (is_digit) begin
               acc = int'(len_acc) * 10 + int'(b - CHAR_ZERO);
               if (acc > int'(ACCUM_SAT))
                  acc = int'(ACCUM_SAT);
               len_acc   = acc[16:0];
               prs_phase = PH_DIGITS;
            end else if (prs_phase == PH_FIRST_DIGIT) begin
               note_error(ST_BAD_LENGTH);
            end else if (len_acc >= {1'b0, lim_elem}) begin
               // length is checked before the period
               note_error(ST_BAD_LENGTH);
            end else if (b != CHAR_PERIOD) begin
               note_error(ST_NO_PERIOD);
            end else begin
               bytes_left = len_acc[15:0];
               len_acc    = '0;
               prs_phase  = (bytes_left == 16'd0) ? PH_SEPARATOR : PH_CONTENT;
            end
         end
         PH_CONTENT: begin
            pending_results.push_back({KIND_CONTENT, b, elem_idx, ST_OK, 1'b0});
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0)
               prs_phase = PH_SEPARATOR;
         end
         PH_SEPARATOR: begin
            if (b == CHAR_COMMA || b == CHAR_SEMI) begin
               pending_results.push_back({KIND_CLOSE, 8'h00, elem_idx, ST_OK, 1'b0});
               if (elem_idx < INDEX_SAT)
                  elem_idx = elem_idx + 16'd1;
               prs_phase = (b == CHAR_COMMA) ? PH_FIRST_DIGIT : PH_DONE;
            end else begin
               note_error(ST_BAD_SEP);
            end
         end
         default: ;  // done or dead: wait for frame end
      endcase

      if (fe) begin
         if (b != CHAR_SEMI)
            st = ST_NO_SEMI;
         else if (frame_len >= {1'b0, lim_frame})
            st = ST_TOO_LONG;
         else if (first_err != ST_OK)
            st = first_err;
         else if (prs_phase != PH_DONE)
            st = ST_TRUNCATED;
         else
            st = ST_OK;
         pending_results.push_back({KIND_STATUS, 8'h00, elem_idx, st, 1'b1});
         clear_frame_state();
      end
   endfunction

   // ------------------------------------------------------------------
   // Idle lengths: mostly none, some short, a few long
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 30);
   endfunction

   // ------------------------------------------------------------------
   // Sender side: one byte per transaction, held until taken
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic fe);
      int gap;
      gap = tx_idling ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_frame_end <= fe;
      // values read right after the edge are those the edge sampled
      do @(posedge clock); while (req_stall);
      parse_frame_byte(b, fe);
      items_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i])
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         frame_buf.push_back(s[i]);
   endfunction

   task automatic send_text(input string s);
      frame_buf.delete();
      put_text(s);
      send_frame();
   endtask

   function automatic logic [7:0] pick_noise_byte();
      case ($urandom_range(0, 4))
         0:       return CHAR_ZERO + 8'($urandom_range(0, 9));
         1:       return CHAR_PERIOD;
         2:       return CHAR_COMMA;
         3:       return CHAR_SEMI;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // "<len>.<content><sep>", content random over the full byte range
   function automatic void put_element(input int len, input logic [7:0] sep,
                                       input bit zero_pad);
      if (zero_pad)
         frame_buf.push_back(CHAR_ZERO);
      put_text($sformatf("%0d", len));
      frame_buf.push_back(CHAR_PERIOD);
      repeat (len)
         frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(sep);
   endfunction

   // Mostly well-formed frames with random content; some get broken on
   // purpose and a few are pure noise.
   function automatic void build_random_frame();
      int n_elem;
      int len;
      int pos;
      frame_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8))
            frame_buf.push_back(pick_noise_byte());
         return;
      end
      n_elem = $urandom_range(1, 4);
      for (int i = 0; i < n_elem; i++) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
         put_element(len, (i == n_elem - 1) ? CHAR_SEMI : CHAR_COMMA,
                     $urandom_range(0, 7) == 0);
      end
      if ($urandom_range(0, 3) != 0)
         return;
      pos = $urandom_range(0, frame_buf.size() - 1);
      case ($urandom_range(0, 4))
         0: frame_buf[pos] = pick_noise_byte();
         1: while (frame_buf.size() > pos + 1) void'(frame_buf.pop_back());
         2: begin
            // trailing junk after the terminator, sometimes closed again
            repeat ($urandom_range(1, 3))
               frame_buf.push_back(pick_noise_byte());
            if ($urandom_range(0, 1) == 1)
               frame_buf.push_back(CHAR_SEMI);
         end
         3: frame_buf.insert(pos, pick_noise_byte());
         default: if (frame_buf.size() > 1) frame_buf.delete(pos);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Idle handling and register writes
   // ------------------------------------------------------------------
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers in back to back writes; only called after drain()
   task automatic set_limits(input logic [15:0] frame_max, input logic [15:0] elem_max);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_MAX_FRAME_BYTES;
      csr_write_data <= frame_max;
      @(posedge clock);
      csr_index      <= CSR_MAX_ELEMENT_BYTES;
      csr_write_data <= elem_max;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      lim_frame = frame_max;
      lim_elem  = elem_max;
   endtask

   // ------------------------------------------------------------------
   // Receiver side: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            rsp_stall <= rx_idling && ($urandom_range(0, 2) == 0);
            repeat (pick_gap()) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checking: each accepted transaction against the oldest entry
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      parse_result_type got;
      parse_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_kind, rsp_content_byte, rsp_element_number, rsp_status, rsp_last};
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result kind=%0d byte=%02h elem=%0d status=%0d last=%0d",
                     $time, got.kind, got.content, got.elem, got.status, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               fail_count++;
               $display("%0t: mismatch expected kind=%0d byte=%02h elem=%0d status=%0d last=%0d",
                        $time, want.kind, want.content, want.elem, want.status, want.last);
               $display("%0t:            actual kind=%0d byte=%02h elem=%0d status=%0d last=%0d",
                        $time, got.kind, got.content, got.elem, got.status, got.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Framing rules under reset limits: good frames, byte extremes as content
   // and every error status but ST_TOO_LONG.
   task automatic test_framing_basics();
      send_text("0.;");                    // empty element, good frame
      frame_buf.delete();
      put_text("2.");
      frame_buf.push_back(8'h00);          // content byte extremes
      frame_buf.push_back(8'hFF);
      frame_buf.push_back(CHAR_SEMI);
      send_frame();
      send_text(";");                      // no digits where a length starts
      send_text("1;");                     // digits not followed by a period
      send_text("0.x;");                   // bad separator after content
      send_text("3.ab;");                  // frame ends inside the element
      send_text("0.;x;");                  // junk after the terminator is ignored
      send_text("9999.;");                 // declared length over the limit
      send_text("0.,");                    // last byte is not a semicolon
   endtask

   // Limit registers: near the bound, zero and all-ones, accumulator saturation.
   task automatic test_csr_limits();
      drain();
      set_limits(16'd8, 16'd5);
      send_text("5.abcde;");               // length equal to the limit
      send_text("4.abcd;");                // one under both limits
      send_text("0.,0.,0.;");              // frame reaches max_frame_bytes
      drain();
      set_limits(16'd0, 16'hFFFF);         // every frame too long
      send_text("0.;");
      drain();
      set_limits(16'hFFFF, 16'd0);         // every element rejected
      send_text("0.;");
      drain();
      set_limits(16'hFFFF, 16'hFFFF);
      send_text("99999999.;");             // accumulator saturates
      send_text("1.;;");
   endtask

   // Hold the receiver off while the sender streams a long element, so the
   // queue fills and req_stall has to rise.
   task automatic test_backpressure();
      drain();
      set_limits(MAX_FRAME_BYTES_RESET, MAX_ELEMENT_BYTES_RESET);
      tx_idling    = 1'b0;
      rx_idling    = 1'b0;
      hold_pending = 1'b1;
      frame_buf.delete();
      put_element(90, CHAR_COMMA, 1'b0);
      put_element(20, CHAR_SEMI, 1'b0);
      send_frame();
      drain();
      tx_idling = 1'b1;
      rx_idling = 1'b1;
   endtask

   // Random frames in four limit settings: reset values, maximum, tight
   // random, and minimum.
   task automatic test_random_traffic();
      logic [15:0] frame_max[4];
      logic [15:0] elem_max[4];
      int          start;
      bit          quiet;
      frame_max = '{MAX_FRAME_BYTES_RESET, 16'hFFFF, 16'($urandom_range(12, 80)), 16'd1};
      elem_max  = '{MAX_ELEMENT_BYTES_RESET, 16'hFFFF, 16'($urandom_range(3, 20)), 16'd1};
      for (int p = 0; p < 4; p++) begin
         drain();
         set_limits(frame_max[p], elem_max[p]);
         start = items_sent;
         while (items_sent - start < RANDOM_ITEMS / 4) begin
            // now and then a stretch with neither side idling
            quiet     = ($urandom_range(0, 4) == 0);
            tx_idling = !quiet;
            rx_idling = !quiet;
            build_random_frame();
            send_frame();
         end
      end
      tx_idling = 1'b1;
      rx_idling = 1'b1;
   endtask

   initial begin
      clear_frame_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_framing_basics();
      test_csr_limits();
      test_backpressure();
      test_random_traffic();

      drain();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
